/* design/swtk_pkg.sv */
// ----------------------------------------------------------------------------
// swtk_pkg
// Shared types and constants of the skin weight top-k accumulator.
// ----------------------------------------------------------------------------
package swtk_pkg;

   // default configuration
   localparam int SLOTS_DEF        = 4;
   localparam int VERTEX_COUNT_DEF = 4096;
   localparam int BONE_COUNT_DEF   = 256;

   // field widths
   localparam int VERTEX_W  = 12;
   localparam int BONE_W    = 8;
   localparam int WEIGHT_W  = 16;
   localparam int SLOTNUM_W = 2;
   localparam int RANGE_W   = 17;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // quotient bits produced by the divider after the saturation check
   localparam int QUOT_STEPS = 16;
   localparam logic [WEIGHT_W-1:0] SAT_WEIGHT = '1;

   // opcodes carried on req_tuser
   localparam logic OP_INSERT    = 1'b0;
   localparam logic OP_NORMALIZE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_INSERT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic item_load;
      logic ent_load;
      logic ins_wr;
      logic norm_wr;
      logic clr_wr;
      logic clr_inc;
      logic slot_clr;
      logic slot_inc;
      logic div_start;
      logic div_store;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_range;
      logic bone_ok;
      logic req_norm;
      logic op_norm;
      logic sum_zero;
      logic div_done;
      logic slot_last;
      logic clr_last;
      logic out_free;
   } ctrl_sts_type;

endpackage

/* design/swtk_ram.sv */
// ----------------------------------------------------------------------------
// swtk_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swtk_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/swtk_div.sv */
// ----------------------------------------------------------------------------
// swtk_div
// Bit-serial restoring divider: floor(dividend * 2^16 / divisor), saturated.
// ----------------------------------------------------------------------------
module swtk_div #(
   parameter int SUM_W = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [swtk_pkg::WEIGHT_W-1:0] dividend,
   input  logic [SUM_W-1:0]              divisor,
   output logic                          done,
   output logic [swtk_pkg::WEIGHT_W-1:0] quotient
);

   localparam int CNT_W = $clog2(swtk_pkg::QUOT_STEPS + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [SUM_W-1:0]              rem_ff, rem_in;
   logic [SUM_W-1:0]              divisor_ff, divisor_in;
   logic [swtk_pkg::WEIGHT_W-1:0] q_ff, q_in;

   logic [SUM_W:0] trial;
   logic [SUM_W:0] diff;
   logic           fits;

   assign trial = {rem_ff, 1'b0};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      q_in       = q_ff;
      if (start) begin
         divisor_in = divisor;
         // the weight can only reach the sum when it is the sole non-zero slot
         if (SUM_W'(dividend) >= divisor) begin
            q_in    = swtk_pkg::SAT_WEIGHT;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = SUM_W'(dividend);
            q_in    = '0;
            cnt_in  = CNT_W'(swtk_pkg::QUOT_STEPS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         q_in   = {q_ff[swtk_pkg::WEIGHT_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      q_ff       <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

/* design/swtk_datapath.sv */
// ----------------------------------------------------------------------------
// swtk_datapath
// Vertex tables, entry registers, insertion network, sum, divider and
// result register.
// ----------------------------------------------------------------------------
module swtk_datapath #(
   parameter int SLOTS        = swtk_pkg::SLOTS_DEF,
   parameter int VERTEX_COUNT = swtk_pkg::VERTEX_COUNT_DEF,
   parameter int BONE_COUNT   = swtk_pkg::BONE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [swtk_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  swtk_pkg::ctrl_cmd_type          cmd,
   output swtk_pkg::ctrl_sts_type          sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swtk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int VW     = swtk_pkg::VERTEX_W;
   localparam int BW     = swtk_pkg::BONE_W;
   localparam int WW     = swtk_pkg::WEIGHT_W;
   localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SUM_W  = WW + $clog2(SLOTS);

   // request fields
   logic [VW-1:0] req_vertex;
   logic [BW-1:0] req_bone;
   logic [WW-1:0] req_weight;

   assign req_vertex = req_tdata[VW-1:0];
   assign req_bone   = req_tdata[VW +: BW];
   assign req_weight = req_tdata[VW+BW +: WW];

   // item registers
   logic [VW-1:0] vertex_ff, vertex_in;
   logic [BW-1:0] bone_ff, bone_in;
   logic [WW-1:0] weight_ff, weight_in;
   logic          op_ff, op_in;

   // entry registers
   logic [WW-1:0]    ent_w_ff [SLOTS];
   logic [WW-1:0]    ent_w_in [SLOTS];
   logic [BW-1:0]    ent_b_ff [SLOTS];
   logic [BW-1:0]    ent_b_in [SLOTS];
   logic [SUM_W-1:0] sum_ff, sum_in;

   // control counters
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                  rsp_vertex_ff, rsp_vertex_in;
   logic [swtk_pkg::SLOTNUM_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [BW-1:0]                  rsp_bone_ff, rsp_bone_in;
   logic [WW-1:0]                  rsp_weight_ff, rsp_weight_in;
   logic                           rsp_last_ff, rsp_last_in;

   // memory ports
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SLOTS*WW-1:0]   wr_w_row;
   logic [SLOTS*BW-1:0]   wr_b_row;
   logic [SLOTS*WW-1:0]   rd_w_row;
   logic [SLOTS*BW-1:0]   rd_b_row;

   logic [SUM_W-1:0] sum_rd;
   logic [WW-1:0]    ins_w [SLOTS];
   logic [BW-1:0]    ins_b [SLOTS];
   logic             div_done;
   logic [WW-1:0]    div_q;

   assign wr_en   = cmd.clr_wr | cmd.ins_wr | cmd.norm_wr;
   assign wr_addr = cmd.clr_wr ? clr_ff : ADDR_W'(vertex_ff);

   swtk_ram #(
      .WIDTH (SLOTS * WW),
      .DEPTH (VERTEX_COUNT)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_w_row),
      .rd_en   (cmd.rd_en),
      .rd_addr (ADDR_W'(req_vertex)),
      .rd_data (rd_w_row)
   );

   swtk_ram #(
      .WIDTH (SLOTS * BW),
      .DEPTH (VERTEX_COUNT)
   ) u_bone_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_b_row),
      .rd_en   (cmd.rd_en),
      .rd_addr (ADDR_W'(req_vertex)),
      .rd_data (rd_b_row)
   );

   swtk_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ent_w_ff[slot_ff]),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // sum of the weights as read from the table
   always_comb begin
      sum_rd = '0;
      for (int i = 0; i < SLOTS; i++) begin
         sum_rd = sum_rd + SUM_W'(rd_w_row[i*WW +: WW]);
      end
   end

   // new pair goes to the first slot it strictly exceeds, later pairs shift up
   always_comb begin
      logic seen;
      logic gt;
      seen = weight_ff > ent_w_ff[0];
      ins_w[0] = seen ? weight_ff : ent_w_ff[0];
      ins_b[0] = seen ? bone_ff : ent_b_ff[0];
      for (int i = 1; i < SLOTS; i++) begin
         gt = weight_ff > ent_w_ff[i];
         if (seen) begin
            ins_w[i] = ent_w_ff[i-1];
            ins_b[i] = ent_b_ff[i-1];
         end else if (gt) begin
            ins_w[i] = weight_ff;
            ins_b[i] = bone_ff;
         end else begin
            ins_w[i] = ent_w_ff[i];
            ins_b[i] = ent_b_ff[i];
         end
         seen = seen | gt;
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (cmd.clr_wr) begin
            wr_w_row[i*WW +: WW] = '0;
            wr_b_row[i*BW +: BW] = '0;
         end else if (cmd.ins_wr) begin
            wr_w_row[i*WW +: WW] = ins_w[i];
            wr_b_row[i*BW +: BW] = ins_b[i];
         end else begin
            wr_w_row[i*WW +: WW] = ent_w_ff[i];
            wr_b_row[i*BW +: BW] = ent_b_ff[i];
         end
      end
   end

   always_comb begin
      vertex_in = vertex_ff;
      bone_in   = bone_ff;
      weight_in = weight_ff;
      op_in     = op_ff;
      if (cmd.item_load) begin
         vertex_in = req_vertex;
         bone_in   = req_bone;
         weight_in = req_weight;
         op_in     = req_tuser;
      end

      ent_w_in = ent_w_ff;
      ent_b_in = ent_b_ff;
      sum_in   = sum_ff;
      if (cmd.ent_load) begin
         for (int i = 0; i < SLOTS; i++) begin
            ent_w_in[i] = rd_w_row[i*WW +: WW];
            ent_b_in[i] = rd_b_row[i*BW +: BW];
         end
         sum_in = sum_rd;
      end
      if (cmd.div_store) begin
         ent_w_in[slot_ff] = div_q;
      end

      slot_in = slot_ff;
      if (cmd.slot_clr) begin
         slot_in = '0;
      end else if (cmd.slot_inc) begin
         slot_in = slot_ff + SLOT_W'(1);
      end

      clr_in = cmd.clr_inc ? clr_ff + ADDR_W'(1) : clr_ff;

      rsp_vertex_in = rsp_vertex_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_bone_in   = rsp_bone_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = vertex_ff;
         rsp_slot_in   = swtk_pkg::SLOTNUM_W'(slot_ff);
         rsp_bone_in   = ent_b_ff[slot_ff];
         rsp_weight_in = ent_w_ff[slot_ff];
         rsp_last_in   = sts.slot_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vertex_ff     <= vertex_in;
      bone_ff       <= bone_in;
      weight_ff     <= weight_in;
      op_ff         <= op_in;
      ent_w_ff      <= ent_w_in;
      ent_b_ff      <= ent_b_in;
      sum_ff        <= sum_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_bone_ff   <= rsp_bone_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      sts.in_range  = swtk_pkg::RANGE_W'(req_vertex) < swtk_pkg::RANGE_W'(VERTEX_COUNT);
      sts.bone_ok   = swtk_pkg::RANGE_W'(req_bone) < swtk_pkg::RANGE_W'(BONE_COUNT);
      sts.req_norm  = req_tuser == swtk_pkg::OP_NORMALIZE;
      sts.op_norm   = op_ff == swtk_pkg::OP_NORMALIZE;
      sts.sum_zero  = sum_ff == '0;
      sts.div_done  = div_done;
      sts.slot_last = slot_ff == SLOT_W'(SLOTS - 1);
      sts.clr_last  = clr_ff == ADDR_W'(VERTEX_COUNT - 1);
      sts.out_free  = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = swtk_pkg::RSP_DATA_W'({rsp_weight_ff, rsp_bone_ff, rsp_slot_ff,
                                              rsp_vertex_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/swtk_ctrl.sv */
// ----------------------------------------------------------------------------
// swtk_ctrl
// Sequencer: table clear, insert read-modify-write, normalize and readout.
// ----------------------------------------------------------------------------
module swtk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  swtk_pkg::ctrl_sts_type sts,
   output swtk_pkg::ctrl_cmd_type cmd
);

   swtk_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swtk_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         swtk_pkg::ST_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.clr_inc = 1'b1;
            if (sts.clr_last) begin
               state_in = swtk_pkg::ST_IDLE;
            end
         end
         swtk_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            // out of range items are taken and dropped
            if (req_tvalid && sts.in_range && (sts.req_norm || sts.bone_ok)) begin
               cmd.item_load = 1'b1;
               cmd.rd_en     = 1'b1;
               state_in      = swtk_pkg::ST_LOAD;
            end
         end
         swtk_pkg::ST_LOAD: begin
            cmd.ent_load = 1'b1;
            cmd.slot_clr = 1'b1;
            state_in = sts.op_norm ? swtk_pkg::ST_DIV_START : swtk_pkg::ST_INSERT;
         end
         swtk_pkg::ST_INSERT: begin
            cmd.ins_wr = 1'b1;
            state_in   = swtk_pkg::ST_IDLE;
         end
         swtk_pkg::ST_DIV_START: begin
            if (sts.sum_zero) begin
               state_in = swtk_pkg::ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = swtk_pkg::ST_DIV_WAIT;
            end
         end
         swtk_pkg::ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (sts.slot_last) begin
                  cmd.slot_clr = 1'b1;
                  state_in     = swtk_pkg::ST_WRITE;
               end else begin
                  cmd.slot_inc = 1'b1;
                  state_in     = swtk_pkg::ST_DIV_START;
               end
            end
         end
         swtk_pkg::ST_WRITE: begin
            cmd.norm_wr = 1'b1;
            state_in    = swtk_pkg::ST_EMIT;
         end
         swtk_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.slot_last) begin
                  state_in = swtk_pkg::ST_IDLE;
               end else begin
                  cmd.slot_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = swtk_pkg::ST_IDLE;
         end
      endcase
   end

   a_load_never_overwrites: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register loaded while a result is waiting");

   a_insert_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_wr |-> $past(cmd.ent_load))
      else $error("insert written back without a fresh entry");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == swtk_pkg::ST_CLEAR) |-> $past(sts.clr_last))
      else $error("table clear left before the last entry");

endmodule

/* design/skin_weight_topk_accumulator.sv */
// ----------------------------------------------------------------------------
// skin_weight_topk_accumulator
// Per-vertex top-k bone weight table with normalization and slot readout.
// ----------------------------------------------------------------------------
// req channel: one transfer per item. tuser selects insert or normalize.
//   An insert places (bone, weight) in the vertex entry, sorted by descending
//   weight, and gives no result. A normalize scales the entry's weights to sum
//   to one in Q0.16, writes them back and returns one rsp transfer per slot,
//   slot 0 first, tlast on the final slot.
// Sequence: an insert passes accept, table read and write back. A normalize
//   passes accept, table read, one run of the bit-serial divider per slot
//   (one quotient bit a cycle), write back and readout. With a zero sum
//   the divider is skipped and the readout follows the read. Out of range
//   items are taken and dropped. A new item is taken only when idle.
// Reset: the controller sweeps the table to zero, one entry a cycle, through
//   all VERTEX_COUNT entries; req_tready stays low meanwhile.
// Stall: results sit in an output register; a low rsp_tready halts the
//   readout, and the next item is taken while the last result still waits.
// ----------------------------------------------------------------------------
module skin_weight_topk_accumulator #(
   parameter int SLOTS        = swtk_pkg::SLOTS_DEF,
   parameter int VERTEX_COUNT = swtk_pkg::VERTEX_COUNT_DEF,
   parameter int BONE_COUNT   = swtk_pkg::BONE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // vertex_index [11:0], bone_index [19:12], weight_value [35:20]
   input  logic [swtk_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_vertex [11:0], slot_number [13:12], slot_bone [21:14], slot_weight [37:22]
   output logic [swtk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   swtk_pkg::ctrl_cmd_type cmd;
   swtk_pkg::ctrl_sts_type sts;

   swtk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   swtk_datapath #(
      .SLOTS        (SLOTS),
      .VERTEX_COUNT (VERTEX_COUNT),
      .BONE_COUNT   (BONE_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
